// File: src/pcicfg_pkg.sv
// Shared types, constants and helper functions for the PCI configuration
// mechanism host bridge. No dependencies; every other file in src uses it.
package pcicfg_pkg;

    // Configuration store geometry: four byte-lane banks of word rows.
    localparam int CONFIG_BYTES = 256;
    localparam int LANES        = 4;
    localparam int WORD_DEPTH   = CONFIG_BYTES / LANES;
    localparam int WORD_W       = $clog2(WORD_DEPTH);
    localparam int ADDR_W       = WORD_W + 2;

    // Transaction kinds and port decode.
    localparam logic       KIND_READ     = 1'b0;
    localparam logic       KIND_WRITE    = 1'b1;
    localparam logic [2:0] OFF_ADDR      = 3'd0;
    localparam int         DATA_PORT_BIT = 2;
    localparam logic [2:0] FULL_SIZE     = 3'd4;
    localparam int         ENABLE_BIT    = 31;

    // Write-protected register ranges (BARs and expansion ROM base).
    localparam logic [7:0] BAR_LO = 8'h10;
    localparam logic [7:0] BAR_HI = 8'h28;
    localparam logic [7:0] ROM_LO = 8'h30;
    localparam logic [7:0] ROM_HI = 8'h34;

    typedef logic [7:0]        t_byte;
    typedef logic [WORD_W-1:0] t_word_idx;

    // Where the read data of a transaction comes from.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_LATCH,
        SRC_DATA,
        SRC_FAIL
    } t_rd_src;

    // Per-bank request from the decoder.
    typedef struct packed {
        logic      we;
        t_word_idx waddr;
        t_byte     wdata;
        t_word_idx raddr;
        t_byte     rst_val;
    } t_bank_req;

    // Result formatting control carried alongside the bank read data.
    typedef struct packed {
        t_rd_src     src;
        logic [1:0]  rot;
        logic [31:0] mask;
        logic [31:0] latch;
    } t_rd_ctl;

    // Reset contents of the store: bridge identity, zero elsewhere.
    function automatic t_byte identity_byte(input logic [ADDR_W-1:0] a);
        t_byte b;
        unique case (a)
            ADDR_W'(8'h00): b = 8'h86;
            ADDR_W'(8'h01): b = 8'h80;
            ADDR_W'(8'h02): b = 8'h37;
            ADDR_W'(8'h03): b = 8'h12;
            ADDR_W'(8'h04): b = 8'h06;
            ADDR_W'(8'h08): b = 8'h02;
            ADDR_W'(8'h0b): b = 8'h06;
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte-lane mask for an access of n bytes (n already clamped to four).
    function automatic logic [31:0] size_mask(input logic [2:0] n);
        logic [31:0] m;
        unique case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// File: src/pcicfg_bank.sv
// One byte lane of the configuration store: a word-indexed memory with
// per-entry valid bits so that unwritten entries read their reset value.
// Depends on pcicfg_pkg.
module pcicfg_bank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic                 i_we,
    input  pcicfg_pkg::t_word_idx i_waddr,
    input  pcicfg_pkg::t_byte    i_wdata,
    input  pcicfg_pkg::t_word_idx i_raddr,
    input  pcicfg_pkg::t_byte    i_rst_val,
    output pcicfg_pkg::t_byte    o_rdata
);

    pcicfg_pkg::t_byte                     r_mem [pcicfg_pkg::WORD_DEPTH];
    logic [pcicfg_pkg::WORD_DEPTH-1:0]     r_valid;
    pcicfg_pkg::t_byte                     r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read an entry never written as its reset value.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : i_rst_val;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/pcicfg_decode.sv
// Decode of one bus transaction against the address latch: target select,
// range checks, per-bank read/write requests and result control.
// Depends on pcicfg_pkg.
module pcicfg_decode (
    input  logic                  i_kind,
    input  logic [2:0]            i_port_offset,
    input  logic [2:0]            i_access_size,
    input  logic [31:0]           i_write_data,
    input  logic [31:0]           i_latch,
    output pcicfg_pkg::t_bank_req o_bank [pcicfg_pkg::LANES],
    output logic                  o_latch_we,
    output pcicfg_pkg::t_rd_ctl   o_ctl
);

    logic [2:0]            n;
    logic                  selected;
    logic [7:0]            reg_addr;
    logic [1:0]            shift;
    logic                  oob;
    logic                  protect;
    logic                  data_port;
    logic                  wr_ok;
    pcicfg_pkg::t_word_idx w0;

    always_comb begin
        n         = (i_access_size > pcicfg_pkg::FULL_SIZE) ? pcicfg_pkg::FULL_SIZE
                                                              : i_access_size;
        selected  = i_latch[pcicfg_pkg::ENABLE_BIT] && (i_latch[23:8] == 16'h0000);
        reg_addr  = {i_latch[7:2], 2'b00} + {6'b000000, i_port_offset[1:0]};
        shift     = reg_addr[1:0];
        w0        = reg_addr[pcicfg_pkg::WORD_W+1:2];
        oob       = ({1'b0, reg_addr} + {6'b000000, n}) > 9'(pcicfg_pkg::CONFIG_BYTES);
        protect   = (reg_addr >= pcicfg_pkg::BAR_LO && reg_addr < pcicfg_pkg::BAR_HI) ||
                    (reg_addr >= pcicfg_pkg::ROM_LO && reg_addr < pcicfg_pkg::ROM_HI);
        data_port = i_port_offset[pcicfg_pkg::DATA_PORT_BIT];
        wr_ok     = (i_kind == pcicfg_pkg::KIND_WRITE) && data_port && selected &&
                    !oob && !protect;
        o_latch_we = (i_kind == pcicfg_pkg::KIND_WRITE) &&
                     (i_port_offset == pcicfg_pkg::OFF_ADDR) &&
                     (i_access_size == pcicfg_pkg::FULL_SIZE);
    end

    // Bank b holds byte i = (b - shift) of the access; lanes below the
    // starting lane fall in the next word.
    always_comb begin
        for (int b = 0; b < pcicfg_pkg::LANES; b++) begin
            logic [1:0]            lane;
            logic [1:0]            idx;
            pcicfg_pkg::t_word_idx w;
            lane = 2'(b);
            idx  = lane - shift;
            w    = w0 + pcicfg_pkg::t_word_idx'(lane < shift);
            o_bank[b].we      = wr_ok && ({1'b0, idx} < n);
            o_bank[b].waddr   = w;
            o_bank[b].wdata   = i_write_data[8*idx +: 8];
            o_bank[b].raddr   = w;
            o_bank[b].rst_val = pcicfg_pkg::identity_byte({w, lane});
        end
    end

    always_comb begin
        o_ctl.rot   = shift;
        o_ctl.mask  = pcicfg_pkg::size_mask(n);
        o_ctl.latch = i_latch;
        if (i_kind == pcicfg_pkg::KIND_READ && i_port_offset == pcicfg_pkg::OFF_ADDR) begin
            o_ctl.src = pcicfg_pkg::SRC_LATCH;
        end else if (i_kind == pcicfg_pkg::KIND_READ && data_port) begin
            o_ctl.src = (selected && !oob) ? pcicfg_pkg::SRC_DATA : pcicfg_pkg::SRC_FAIL;
        end else begin
            o_ctl.src = pcicfg_pkg::SRC_ZERO;
        end
    end

endmodule

// File: src/pcicfg_format.sv
// Result assembly: pick zero, the latch, all ones or the bank bytes rotated
// into access order, and mask to the access size. Depends on pcicfg_pkg.
module pcicfg_format (
    input  pcicfg_pkg::t_rd_ctl i_ctl,
    input  pcicfg_pkg::t_byte   i_rdata [pcicfg_pkg::LANES],
    output logic [31:0]         o_read_data
);

    logic [31:0] raw;
    logic [63:0] both;
    logic [31:0] rotated;

    always_comb begin
        raw     = {i_rdata[3], i_rdata[2], i_rdata[1], i_rdata[0]};
        both    = {raw, raw} >> {i_ctl.rot, 3'b000};
        rotated = both[31:0];
        unique case (i_ctl.src)
            pcicfg_pkg::SRC_ZERO:  o_read_data = 32'h0000_0000;
            pcicfg_pkg::SRC_LATCH: o_read_data = i_ctl.latch & i_ctl.mask;
            pcicfg_pkg::SRC_DATA:  o_read_data = rotated & i_ctl.mask;
            pcicfg_pkg::SRC_FAIL:  o_read_data = i_ctl.mask;
            default:               o_read_data = 32'h0000_0000;
        endcase
    end

endmodule

// File: src/pci_config_mechanism_host_bridge.sv
// Top level of the PCI configuration mechanism host bridge.
// Depends on pcicfg_pkg, pcicfg_decode, pcicfg_bank and pcicfg_format.
//
// Configuration address/data port pair in front of a single host bridge
// (bus 0, device 0, function 0). Port offset 0 is the 32-bit address latch
// (a write needs exactly four bytes); offsets 4 to 7 are the data byte
// lanes into a 256-byte configuration store that resets to the bridge
// identity. Every transaction, read or write, returns one result; writes
// and reads at offsets 1 to 3 return zero. The block takes one transaction
// per cycle while the output is not stalled, and passes each through the
// input register, where the latch and store are decoded, written and
// read, and then the result stage fed by the registered bank reads. The
// store is four byte-lane banks, each read and written at one address per
// cycle, so a four-byte access that crosses a word row still completes in
// one pass. Reset is immediate: per-entry valid bits make unwritten entries
// read as their reset value, with no clearing pass. The input register
// can still take a transaction while a finished result waits under output
// stall, and backs up only when both stages are full and the output stalls.
module pci_config_mechanism_host_bridge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [2:0]  i_port_offset,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data
);

    // Input register (decode stage).
    logic        r_v1;
    logic        r_kind;
    logic [2:0]  r_off;
    logic [2:0]  r_size;
    logic [31:0] r_wdata;

    // Address latch.
    logic [31:0] r_latch;

    // Result stage.
    logic                r_v2;
    pcicfg_pkg::t_rd_ctl r_ctl;

    logic en2;
    logic adv1;
    logic load1;

    pcicfg_pkg::t_bank_req bank_req [pcicfg_pkg::LANES];
    pcicfg_pkg::t_byte     bank_q   [pcicfg_pkg::LANES];
    pcicfg_pkg::t_rd_ctl   ctl;
    logic                  latch_we;

    // Result stage can take a new transaction when empty or being drained.
    assign en2   = !r_v2 || !i_stall;
    // A transaction leaves the decode stage: commit its side effects.
    assign adv1  = r_v1 && en2;
    assign load1 = !r_v1 || en2;

    assign o_stall = !load1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= i_valid;
        end
    end

    // Hold the payload until the decode stage advances.
    always_ff @(posedge i_clk) begin
        if (load1 && i_valid) begin
            r_kind  <= i_kind;
            r_off   <= i_port_offset;
            r_size  <= i_access_size;
            r_wdata <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
        end else if (adv1 && latch_we) begin
            r_latch <= r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_ctl <= ctl;
        end
    end

    pcicfg_decode u_decode (
        .i_kind        (r_kind),
        .i_port_offset (r_off),
        .i_access_size (r_size),
        .i_write_data  (r_wdata),
        .i_latch       (r_latch),
        .o_bank        (bank_req),
        .o_latch_we    (latch_we),
        .o_ctl         (ctl)
    );

    // One bank per byte lane; reads are registered into the result stage.
    for (genvar b = 0; b < pcicfg_pkg::LANES; b++) begin : g_bank
        pcicfg_bank u_bank (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_rd_en   (adv1),
            .i_we      (adv1 && bank_req[b].we),
            .i_waddr   (bank_req[b].waddr),
            .i_wdata   (bank_req[b].wdata),
            .i_raddr   (bank_req[b].raddr),
            .i_rst_val (bank_req[b].rst_val),
            .o_rdata   (bank_q[b])
        );
    end

    pcicfg_format u_format (
        .i_ctl       (r_ctl),
        .i_rdata     (bank_q),
        .o_read_data (o_read_data)
    );

    // The latch changes only when a full-size address-port write commits.
    a_latch_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_latch != $past(r_latch)) |->
            $past(adv1 && r_kind == pcicfg_pkg::KIND_WRITE &&
                  r_off == pcicfg_pkg::OFF_ADDR))
        else $error("address latch changed without a latch write");

    // Reads never write the store.
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_kind == pcicfg_pkg::KIND_READ |->
            !(bank_req[0].we || bank_req[1].we || bank_req[2].we || bank_req[3].we))
        else $error("store write decoded for a read transaction");

    // Store writes only reach an enabled target.
    a_write_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bank_req[0].we || bank_req[1].we || bank_req[2].we || bank_req[3].we) |->
            r_latch[pcicfg_pkg::ENABLE_BIT])
        else $error("store write with target disabled");

    // A committed write shows up next cycle as a zero result.
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 && r_kind == pcicfg_pkg::KIND_WRITE |=>
            o_valid && (o_read_data == 32'h0000_0000))
        else $error("write transaction returned nonzero data");

endmodule

// File: verif/tb_pci_config_mechanism_host_bridge.sv
// Self-checking testbench for pci_config_mechanism_host_bridge: directed and random
// address-latch and data-port transactions checked against an in-bench predictor.
// Depends on pcicfg_pkg and the block's RTL; it reads no files.
module tb_pci_config_mechanism_host_bridge;
    timeunit 1ns;
    timeprecision 1ps;

    // Port window decode. Offset 0 (OFF_ADDR) is the address latch.
    // Offsets 1 to 3 decode to nothing. Offsets 4 to 7 are the data byte lanes.
    localparam logic [2:0] OFF_RSVD1    = 3'd1;
    localparam logic [2:0] OFF_RSVD2    = 3'd2;
    localparam logic [2:0] OFF_RSVD3    = 3'd3;
    localparam logic [2:0] OFF_DATA_B0  = 3'd4;
    localparam logic [2:0] OFF_DATA_B1  = 3'd5;
    localparam logic [2:0] OFF_DATA_B2  = 3'd6;
    localparam logic [2:0] OFF_DATA_B3  = 3'd7;
    localparam logic [31:0] ENABLE_MASK = 32'h1 << pcicfg_pkg::ENABLE_BIT;

    // Cycles to keep running once every expected result has been checked.
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_kind;
    logic [2:0]  i_port_offset;
    logic [2:0]  i_access_size;
    logic [31:0] i_write_data;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_read_data;

    // Predictor state: a private copy of the latch and the configuration store.
    logic [31:0]       cfg_latch;
    pcicfg_pkg::t_byte cfg_store [pcicfg_pkg::CONFIG_BYTES];

    // Read data still owed by the block, oldest first.
    logic [31:0] pending_read_data [$];
    int          err_count;
    bit          src_idle_en;
    bit          sink_stall_en;

    pci_config_mechanism_host_bridge DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_port_offset (i_port_offset),
        .i_access_size (i_access_size),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Put the store back in its power-up state: the bridge identity, zeros elsewhere.
    task automatic reset_cfg_model();
        cfg_latch = '0;
        foreach (cfg_store[a]) cfg_store[a] = 8'h00;
        cfg_store[8'h00] = 8'h86;
        cfg_store[8'h01] = 8'h80;
        cfg_store[8'h02] = 8'h37;
        cfg_store[8'h03] = 8'h12;
        cfg_store[8'h04] = 8'h06;
        cfg_store[8'h08] = 8'h02;
        cfg_store[8'h0b] = 8'h06;
    endtask

    function automatic logic [31:0] byte_lane_mask(input int nbytes);
        if (nbytes >= 4) return 32'hffff_ffff;
        return (32'h1 << (8 * nbytes)) - 32'h1;
    endfunction

    // Apply one transaction to the predictor state and return the read data it yields.
    function automatic logic [31:0] cfg_access_result(input logic kind,
                                                      input logic [2:0] offset,
                                                      input logic [2:0] size,
                                                      input logic [31:0] wdata);
        int          nbytes;
        int          reg_idx;
        bit          selected;
        bit          in_range;
        logic [31:0] rdata;
        nbytes   = (size > pcicfg_pkg::FULL_SIZE) ? 4 : int'(size);
        // Only bus 0, device 0, function 0 answers, and only while enabled.
        selected = cfg_latch[pcicfg_pkg::ENABLE_BIT] && (cfg_latch[23:8] == 16'h0);
        // The register field is dword aligned. The lane adds inside 8 bits.
        reg_idx  = int'(8'({cfg_latch[7:2], 2'b00} + 8'(offset[1:0])));
        in_range = (reg_idx + nbytes) <= pcicfg_pkg::CONFIG_BYTES;
        rdata    = '0;
        if (kind == pcicfg_pkg::KIND_READ) begin
            if (offset == pcicfg_pkg::OFF_ADDR) begin
                rdata = cfg_latch & byte_lane_mask(nbytes);
            end else if (offset[pcicfg_pkg::DATA_PORT_BIT]) begin
                if (!selected || !in_range) begin
                    rdata = byte_lane_mask(nbytes);
                end else begin
                    for (int i = 0; i < nbytes; i++)
                        rdata |= 32'(cfg_store[reg_idx + i]) << (8 * i);
                end
            end
        end else begin
            if (offset == pcicfg_pkg::OFF_ADDR) begin
                // A latch write takes effect only with exactly four bytes.
                if (size == pcicfg_pkg::FULL_SIZE) cfg_latch = wdata;
            end else if (offset[pcicfg_pkg::DATA_PORT_BIT] && selected && in_range &&
                         !(reg_idx >= pcicfg_pkg::BAR_LO && reg_idx < pcicfg_pkg::BAR_HI) &&
                         !(reg_idx >= pcicfg_pkg::ROM_LO && reg_idx < pcicfg_pkg::ROM_HI)) begin
                for (int i = 0; i < nbytes; i++)
                    cfg_store[reg_idx + i] = wdata[8 * i +: 8];
            end
        end
        return rdata;
    endfunction

    // Drive one transaction and hold it until accepted, then record its expected read data.
    // Enter and leave on a falling edge. When no gap is taken, keep valid high.
    task automatic send_txn(input logic kind, input logic [2:0] offset,
                            input logic [2:0] size, input logic [31:0] wdata);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_port_offset <= offset;
        i_access_size <= size;
        i_write_data  <= wdata;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_read_data.push_back(cfg_access_result(kind, offset, size, wdata));
        @(negedge i_clk);
    endtask

    task automatic set_latch(input logic [31:0] value);
        send_txn(pcicfg_pkg::KIND_WRITE, pcicfg_pkg::OFF_ADDR, pcicfg_pkg::FULL_SIZE, value);
    endtask

    // Bridge identity bytes are present straight out of reset.
    task automatic test_reset_identity();
        set_latch(ENABLE_MASK | 32'h00);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B0, pcicfg_pkg::FULL_SIZE, 32'h0);
        set_latch(ENABLE_MASK | 32'h08);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B0, 3'd7, 32'hffff_ffff);
    endtask

    // Latch reads at full, zero and three-byte sizes. Latch writes that are not four bytes are dropped.
    task automatic test_latch_port();
        send_txn(pcicfg_pkg::KIND_WRITE, pcicfg_pkg::OFF_ADDR, 3'd2, 32'h1234_5678);
        send_txn(pcicfg_pkg::KIND_WRITE, pcicfg_pkg::OFF_ADDR, 3'd6, 32'h0000_0000);
        send_txn(pcicfg_pkg::KIND_READ, pcicfg_pkg::OFF_ADDR, pcicfg_pkg::FULL_SIZE, 32'h0);
        send_txn(pcicfg_pkg::KIND_READ, pcicfg_pkg::OFF_ADDR, 3'd0, 32'h0);
        send_txn(pcicfg_pkg::KIND_READ, pcicfg_pkg::OFF_ADDR, 3'd3, 32'h0);
    endtask

    // Offsets 1 to 3 decode to nothing: reads return zero, and writes change nothing.
    task automatic test_unused_offsets();
        send_txn(pcicfg_pkg::KIND_READ, OFF_RSVD1, pcicfg_pkg::FULL_SIZE, 32'h0);
        send_txn(pcicfg_pkg::KIND_WRITE, OFF_RSVD2, pcicfg_pkg::FULL_SIZE, 32'hdead_beef);
        send_txn(pcicfg_pkg::KIND_READ, OFF_RSVD3, 3'd7, 32'h0);
    endtask

    // Disabled, foreign bus, and foreign device/function: reads float high, and writes are dropped.
    task automatic test_target_select();
        set_latch(32'h0000_0040);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B0, 3'd2, 32'h0);
        set_latch(ENABLE_MASK | 32'h00ff_0040);
        send_txn(pcicfg_pkg::KIND_WRITE, OFF_DATA_B0, pcicfg_pkg::FULL_SIZE, 32'h5a5a_5a5a);
        set_latch(ENABLE_MASK | 32'h0000_ff40);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B2, pcicfg_pkg::FULL_SIZE, 32'h0);
    endtask

    // Lanes at the top of the store, an access that runs past its end, zero-byte accesses,
    // and the write-protected BAR and ROM windows.
    task automatic test_data_lanes();
        set_latch(ENABLE_MASK | 32'h7f00_00ff);
        send_txn(pcicfg_pkg::KIND_WRITE, OFF_DATA_B3, 3'd1, 32'h0000_00a5);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B0, pcicfg_pkg::FULL_SIZE, 32'h0);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B2, 3'd5, 32'h0);
        send_txn(pcicfg_pkg::KIND_WRITE, OFF_DATA_B1, 3'd0, 32'hffff_ffff);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B3, 3'd0, 32'h0);
        set_latch(ENABLE_MASK | 32'h10);
        send_txn(pcicfg_pkg::KIND_WRITE, OFF_DATA_B0, pcicfg_pkg::FULL_SIZE, 32'hffff_ffff);
        send_txn(pcicfg_pkg::KIND_READ, OFF_DATA_B0, pcicfg_pkg::FULL_SIZE, 32'h0);
        set_latch(ENABLE_MASK | 32'h30);
        send_txn(pcicfg_pkg::KIND_WRITE, OFF_DATA_B3, 3'd2, 32'hffff_ffff);
    endtask

    // Random traffic. Mostly, program the latch to a live register, then make data
    // transactions there. Add noise: latch values that are wild or disabled, odd sizes,
    // and unused offsets.
    task automatic test_random_traffic(input int count);
        logic [7:0]  reg_pick;
        logic [2:0]  size;
        logic [31:0] value;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                size = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
            end else begin
                size = 3'($urandom_range(1, 4));
            end
            if (pick < 15) begin
                // Bias the register field toward the protected windows and the store end.
                case ($urandom_range(0, 7))
                    0:       reg_pick = 8'($urandom_range(8'h0c, 8'h13));
                    1:       reg_pick = 8'($urandom_range(8'h24, 8'h37));
                    2:       reg_pick = 8'($urandom_range(8'hf8, 8'hff));
                    default: reg_pick = 8'($urandom_range(0, 255));
                endcase
                value = ENABLE_MASK | {1'b0, 7'($urandom), 16'h0, reg_pick};
                set_latch(value);
            end else if (pick < 23) begin
                value = $urandom;
                send_txn(pcicfg_pkg::KIND_WRITE, pcicfg_pkg::OFF_ADDR,
                         ($urandom_range(0, 1) != 0) ? pcicfg_pkg::FULL_SIZE : size, value);
            end else if (pick < 30) begin
                send_txn(pcicfg_pkg::KIND_READ, pcicfg_pkg::OFF_ADDR, size, $urandom);
            end else if (pick < 35) begin
                send_txn(1'($urandom), 3'($urandom_range(1, 3)), size, $urandom);
            end else begin
                send_txn(1'($urandom), 3'($urandom_range(4, 7)), size, $urandom);
            end
        end
    endtask

    // Sink side: stall in random bursts. Change only on the falling edge.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Check each transaction that leaves the block against the oldest expectation.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_read_data.size() == 0) begin
                $error("unexpected transaction: read_data actual %08h", o_read_data);
                err_count++;
            end else begin
                want = pending_read_data.pop_front();
                if (o_read_data !== want) begin
                    $error("read_data mismatch: expected %08h actual %08h", want, o_read_data);
                    err_count++;
                end
            end
        end
    end

    // Hard stop if the block hangs.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        err_count     = 0;
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = pcicfg_pkg::KIND_READ;
        i_port_offset = pcicfg_pkg::OFF_ADDR;
        i_access_size = pcicfg_pkg::FULL_SIZE;
        i_write_data  = '0;
        reset_cfg_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_identity();
        test_latch_port();
        test_unused_offsets();
        test_target_select();
        test_data_lanes();
        test_random_traffic(1150);
        // For the last part, run at full rate with no idling on either side.
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        test_random_traffic(250);
        i_valid <= 1'b0;

        while (pending_read_data.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
